// ===== rtl/owned_key_table_store_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the owned key table store
// Shared concurrent assertion forms, all reset-qualified on rst_ni.
// ----------------------------------------------------------------------------
`ifndef OWNED_KEY_TABLE_STORE_MACROS_SVH
`define OWNED_KEY_TABLE_STORE_MACROS_SVH

// same-cycle implication
`define OKTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OKTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/okts_pkg.sv =====
// ----------------------------------------------------------------------------
// Owned key table store package
// Commands, status codes, sequencer states, transfer structs and defaults.
// ----------------------------------------------------------------------------
package okts_pkg;

  localparam int unsigned EntriesDef  = 16;
  localparam int unsigned NameBitsDef = 64;
  localparam int unsigned DataBitsDef = 64;

  localparam logic [4:0]  MaxEntriesRst = 5'd16;
  localparam logic [15:0] MaxAppIdRst   = 16'hFFFF;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_PRELOAD = 3'd1,
    CMD_GET     = 3'd2,
    CMD_GET_IDX = 3'd3,
    CMD_DELETE  = 3'd4,
    CMD_WIPE    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_SPACE     = 3'd2,
    ST_DUP       = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_READ_ONLY = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    CFG_MAX_ENTRIES = 1'd0,
    CFG_MAX_APP_ID  = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_IDX_RD,
    FSM_IDX_CHK,
    FSM_FINISH
  } fsm_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] app_id;
    logic [4:0]  entry_index;
    logic [63:0] key_name;
    logic [63:0] key_data;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  slot;
    logic [63:0] found_name;
    logic [63:0] found_data;
    logic        found_read_only;
  } out_t;

endpackage

// ===== rtl/okts_mem.sv =====
// ----------------------------------------------------------------------------
// Key table entry memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module okts_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 144,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/owned_key_table_store.sv =====
// ----------------------------------------------------------------------------
// Owned key table store
// Key slot table with owner checks, walked one slot per cycle from memory.
// ----------------------------------------------------------------------------
// Owner, name and key data of each slot sit in a one-port-read memory; used
// and read-only marks sit in flip-flops cleared at reset. Add, preload, get
// and delete walk all count = min(max_entries, ENTRIES) slots, one memory read
// a cycle, before the result is written. Get by index reads one slot and
// checks it before the result; wipe, unknown commands, refused owner ids
// and out-of-range indexes go straight to the finish state. One command is
// handled at a time, and the block returns to idle before the next is
// taken; a finished result waits in the output register while the next
// command is taken.
module owned_key_table_store
  import okts_pkg::*;
#(
  parameter int unsigned ENTRIES   = EntriesDef,
  parameter int unsigned NAME_BITS = NameBitsDef,
  parameter int unsigned DATA_BITS = DataBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o
);

  `include "owned_key_table_store_macros.svh"

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned SW = (CW > 5) ? CW : 5;
  localparam int unsigned MW = 16 + NAME_BITS + DATA_BITS;

  logic [4:0]  max_entries_q;
  logic [15:0] max_app_id_q;

  fsm_e state_q, state_d;

  logic [ENTRIES-1:0] used_q, used_d;
  logic [ENTRIES-1:0] locked_q, locked_d;

  cmd_e                 cmd_q, cmd_d;
  logic [15:0]          owner_q, owner_d;
  logic [SW-1:0]        idx_q, idx_d;
  logic [NAME_BITS-1:0] name_q, name_d;
  logic [DATA_BITS-1:0] data_q, data_d;
  logic [SW-1:0]        count_q, count_d;
  logic                 bad_q, bad_d;
  logic [SW-1:0]        k_q, k_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [IW-1:0]        chk_q, chk_d;
  logic                 hit_q, hit_d;
  logic [IW-1:0]        hit_idx_q, hit_idx_d;
  logic                 free_q, free_d;
  logic [IW-1:0]        free_idx_q, free_idx_d;
  logic                 nf_q, nf_d;
  logic [NAME_BITS-1:0] fnd_name_q, fnd_name_d;
  logic [DATA_BITS-1:0] fnd_data_q, fnd_data_d;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata, mem_rdata;

  logic [15:0]          rd_owner;
  logic [NAME_BITS-1:0] rd_name;
  logic [DATA_BITS-1:0] rd_data;

  logic [SW-1:0] cur_count;
  logic          cur_bad;

  assign rd_owner = mem_rdata[MW-1 -: 16];
  assign rd_name  = mem_rdata[DATA_BITS +: NAME_BITS];
  assign rd_data  = mem_rdata[DATA_BITS-1:0];

  assign cur_count = (SW'(max_entries_q) > SW'(ENTRIES)) ? SW'(ENTRIES) : SW'(max_entries_q);
  assign cur_bad   = in_data_i.app_id > max_app_id_q;

  okts_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (MW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MaxEntriesRst;
      max_app_id_q  <= MaxAppIdRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_ENTRIES: max_entries_q <= cfg_wdata_i[4:0];
        CFG_MAX_APP_ID:  max_app_id_q  <= cfg_wdata_i;
        default:         max_app_id_q  <= max_app_id_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      used_q      <= '0;
      locked_q    <= '0;
      out_valid_q <= 1'b0;
      chk_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      locked_q    <= locked_d;
      out_valid_q <= out_valid_d;
      chk_vld_q   <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    owner_q    <= owner_d;
    idx_q      <= idx_d;
    name_q     <= name_d;
    data_q     <= data_d;
    count_q    <= count_d;
    bad_q      <= bad_d;
    k_q        <= k_d;
    chk_q      <= chk_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    nf_q       <= nf_d;
    fnd_name_q <= fnd_name_d;
    fnd_data_q <= fnd_data_d;
    out_q      <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    locked_d    = locked_q;
    cmd_d       = cmd_q;
    owner_d     = owner_q;
    idx_d       = idx_q;
    name_d      = name_q;
    data_d      = data_q;
    count_d     = count_q;
    bad_d       = bad_q;
    k_d         = k_q;
    chk_vld_d   = 1'b0;
    chk_d       = chk_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    nf_d        = nf_q;
    fnd_name_d  = fnd_name_q;
    fnd_data_d  = fnd_data_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = free_idx_q;
    mem_wdata   = {owner_q, name_q, data_q};
    mem_re      = 1'b0;
    mem_raddr   = k_q[IW-1:0];
    in_stall_o  = (state_q != FSM_IDLE);

    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_e'(in_data_i.command);
          owner_d = in_data_i.app_id;
          idx_d   = SW'(in_data_i.entry_index);
          name_d  = in_data_i.key_name[NAME_BITS-1:0];
          data_d  = in_data_i.key_data[DATA_BITS-1:0];
          count_d = cur_count;
          bad_d   = cur_bad;
          k_d     = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          nf_d    = 1'b0;
          state_d = FSM_FINISH;
          if (!cur_bad) begin
            if (in_data_i.command inside {CMD_ADD, CMD_PRELOAD, CMD_GET, CMD_DELETE}) begin
              state_d = FSM_SCAN;
            end else if (in_data_i.command == CMD_GET_IDX &&
                         SW'(in_data_i.entry_index) < cur_count) begin
              state_d = FSM_IDX_RD;
            end
          end
        end
      end
      FSM_SCAN: begin
        if (k_q < count_q) begin
          mem_re    = 1'b1;
          chk_vld_d = 1'b1;
          chk_d     = k_q[IW-1:0];
          k_d       = k_q + SW'(1);
          if (!used_q[k_q[IW-1:0]] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = k_q[IW-1:0];
          end
        end
        if (chk_vld_q && !hit_q && used_q[chk_q] &&
            rd_owner == owner_q && rd_name == name_q) begin
          hit_d      = 1'b1;
          hit_idx_d  = chk_q;
          fnd_name_d = rd_name;
          fnd_data_d = rd_data;
        end
        if (k_q >= count_q && !chk_vld_q) begin
          state_d = FSM_FINISH;
        end
      end
      FSM_IDX_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q[IW-1:0];
        state_d   = FSM_IDX_CHK;
      end
      FSM_IDX_CHK: begin
        nf_d       = !used_q[idx_q[IW-1:0]];
        hit_d      = used_q[idx_q[IW-1:0]] && rd_owner == owner_q;
        fnd_name_d = rd_name;
        fnd_data_d = rd_data;
        state_d    = FSM_FINISH;
      end
      FSM_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          state_d             = FSM_IDLE;
          out_d.status        = ST_INVALID;
          out_d.slot          = 5'(count_q);
          out_d.found_name    = '0;
          out_d.found_data    = '0;
          out_d.found_read_only = 1'b0;
          case (cmd_q)
            CMD_ADD, CMD_PRELOAD: begin
              if (!bad_q) begin
                if (!free_q) begin
                  out_d.status = ST_SPACE;
                end else if (hit_q) begin
                  out_d.status = ST_DUP;
                  out_d.slot   = 5'(hit_idx_q);
                end else begin
                  out_d.status           = ST_OK;
                  out_d.slot             = 5'(free_idx_q);
                  mem_we                 = 1'b1;
                  used_d[free_idx_q]     = 1'b1;
                  locked_d[free_idx_q]   = (cmd_q == CMD_PRELOAD);
                end
              end
            end
            CMD_GET: begin
              if (!bad_q) begin
                if (!hit_q) begin
                  out_d.status = ST_NOT_FOUND;
                end else begin
                  out_d.status          = ST_OK;
                  out_d.slot            = 5'(hit_idx_q);
                  out_d.found_name      = 64'(fnd_name_q);
                  out_d.found_data      = 64'(fnd_data_q);
                  out_d.found_read_only = locked_q[hit_idx_q];
                end
              end
            end
            CMD_GET_IDX: begin
              if (!bad_q && idx_q < count_q) begin
                if (nf_q) begin
                  out_d.status = ST_NOT_FOUND;
                end else if (hit_q) begin
                  out_d.status          = ST_OK;
                  out_d.slot            = 5'(idx_q);
                  out_d.found_name      = 64'(fnd_name_q);
                  out_d.found_data      = 64'(fnd_data_q);
                  out_d.found_read_only = locked_q[idx_q[IW-1:0]];
                end
              end
            end
            CMD_DELETE: begin
              if (!bad_q) begin
                if (!hit_q) begin
                  out_d.status = ST_NOT_FOUND;
                end else begin
                  out_d.slot = 5'(hit_idx_q);
                  if (locked_q[hit_idx_q]) begin
                    out_d.status = ST_READ_ONLY;
                  end else begin
                    out_d.status      = ST_OK;
                    used_d[hit_idx_q] = 1'b0;
                  end
                end
              end
            end
            CMD_WIPE: begin
              out_d.status = ST_OK;
              for (int i = 0; i < ENTRIES; i++) begin
                if (SW'(i) < count_q && !locked_q[i]) begin
                  used_d[i] = 1'b0;
                end
              end
            end
            default: begin
              out_d.status = ST_INVALID;
            end
          endcase
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `OKTS_ASSERT_IMP(a_scan_bound, state_q == FSM_SCAN, k_q <= count_q, "scan ran past count")
  `OKTS_ASSERT_NXT(a_out_hold, out_valid_q && out_stall_i, out_valid_q && $stable(out_q), "result lost under stall")
  `OKTS_ASSERT_IMP(a_get_hit_used, state_q == FSM_FINISH && cmd_q == CMD_GET && hit_q, used_q[hit_idx_q], "get hit on free slot")
  `OKTS_ASSERT_IMP(a_free_slot, state_q == FSM_FINISH && free_q, !used_q[free_idx_q] && SW'(free_idx_q) < count_q, "free slot not free")

endmodule
